FILE: hw/rtl/dsb_pkg.sv
// Shared types and constants of the disparity shift blend core.
`default_nettype none

package dsb_pkg;

	localparam int ROW_WIDTH_W = 11;
	localparam int SHIFT_W     = 7;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 1;

	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(640);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROW_WIDTH    = 1'b0,
		REG_SHIFT_AMOUNT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef enum logic {
		ST_RUN,
		ST_FLUSH
	} state_t;

	// what the stage-1 entry turns into at the output register
	typedef enum logic [1:0] {
		K_BLEND_MEM,
		K_BLEND_REG,
		K_COPY
	} s1_kind_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ring_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dsb_in_if.sv
// Input channel: one left and one right RGB pixel of the same column.
`default_nettype none

interface dsb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] left_red;
	logic [7:0] left_green;
	logic [7:0] left_blue;
	logic [7:0] right_red;
	logic [7:0] right_green;
	logic [7:0] right_blue;

	modport source (
		output valid, left_red, left_green, left_blue, right_red, right_green, right_blue,
		input  ready
	);

	modport sink (
		input  valid, left_red, left_green, left_blue, right_red, right_green, right_blue,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/dsb_out_if.sv
// Output channel: one blended or copied RGB pixel with end-of-row flag.
`default_nettype none

interface dsb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       row_last;

	modport source (
		output valid, out_red, out_green, out_blue, row_last,
		input  ready
	);

	modport sink (
		input  valid, out_red, out_green, out_blue, row_last,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/dsb_ring.sv
// Delay ring memory: one write and one registered read per cycle.
`default_nettype none

module dsb_ring #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  wire                      clk,
	input  wire dsb_pkg::ring_ctl_t  ctl,
	input  wire  [ADDR_W-1:0]        wr_addr,
	input  wire dsb_pkg::rgb_t       wr_data,
	input  wire  [ADDR_W-1:0]        rd_addr,
	output dsb_pkg::rgb_t            rd_data
);
	import dsb_pkg::*;

	rgb_t mem [DEPTH];

	// read returns old data when both ports hit the same entry
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/disparity_shift_blend_core.sv
// Disparity shift blend core: top level with row control, ring access and output register.
// Path: an accepted input goes through the ring read into the stage-1 register, then into the
//   output register, whose valid drives the output channel; back-pressure can hold either one.
// Throughput: one input transaction per cycle within a row while the output is not stalled;
//   the last pixel of a row starts a flush of |s| ring reads, during which no input is taken.
// Reset: arst_n clears all control state asynchronously; row_width resets to 640, shift to 0.
//   The ring is not cleared: an entry is always written earlier in the same row than it is read.
`default_nettype none

module disparity_shift_blend_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SHIFT = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [dsb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire  [dsb_pkg::CFG_DATA_W-1:0]      cfg_data,
	dsb_in_if.sink                              pixels,
	dsb_out_if.source                           blended
);
	import dsb_pkg::*;

	localparam int LEN_W = $clog2(MAX_WIDTH + 1);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int MAG_W = $clog2(MAX_SHIFT + 1);
	localparam int PTR_W = (MAX_SHIFT > 1) ? $clog2(MAX_SHIFT) : 1;
	localparam int CMP_W = ((LEN_W > ROW_WIDTH_W) ? LEN_W : ROW_WIDTH_W) + 1;

	function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] ptr,
			input logic [MAG_W-1:0] back);
		logic [MAG_W:0] sum;
		sum = (MAG_W+1)'(ptr) + (MAG_W+1)'(MAX_SHIFT) - (MAG_W+1)'(back);
		if (sum >= (MAG_W+1)'(MAX_SHIFT)) begin
			sum = sum - (MAG_W+1)'(MAX_SHIFT);
		end
		return PTR_W'(sum);
	endfunction

	function automatic rgb_t blend(input rgb_t a, input rgb_t b);
		logic [8:0] sr;
		logic [8:0] sg;
		logic [8:0] sb;
		rgb_t       res;
		sr = {1'b0, a.red} + {1'b0, b.red};
		sg = {1'b0, a.green} + {1'b0, b.green};
		sb = {1'b0, a.blue} + {1'b0, b.blue};
		res.red   = sr[8:1];
		res.green = sg[8:1];
		res.blue  = sb[8:1];
		return res;
	endfunction

	// configuration registers
	logic        [ROW_WIDTH_W-1:0] row_width_q;
	logic signed [SHIFT_W-1:0]     shift_amount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q    <= ROW_WIDTH_RESET;
			shift_amount_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_WIDTH:    row_width_q    <= cfg_data[ROW_WIDTH_W-1:0];
				REG_SHIFT_AMOUNT: shift_amount_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// row state
	state_t           state_q;
	state_t           state_d;
	logic [COL_W-1:0] col_q;
	logic [LEN_W-1:0] row_len_q;
	logic [MAG_W-1:0] row_mag_q;
	logic             row_neg_q;
	logic [PTR_W-1:0] wp_q;
	logic [MAG_W-1:0] flush_cnt_q;
	logic [PTR_W-1:0] flush_addr_q;

	// row parameters as sampled at column 0
	logic [CMP_W-1:0]   w_ext;
	logic [CMP_W-1:0]   len_c;
	logic [CMP_W-1:0]   lim_c;
	logic [CMP_W-1:0]   magraw_c;
	logic [CMP_W-1:0]   mag_c;
	logic [SHIFT_W-1:0] sh_neg;

	always_comb begin
		w_ext = CMP_W'(row_width_q);
		if (w_ext == '0) begin
			len_c = CMP_W'(1);
		end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
			len_c = CMP_W'(MAX_WIDTH);
		end else begin
			len_c = w_ext;
		end
		lim_c = len_c - CMP_W'(1);
		if (lim_c > CMP_W'(MAX_SHIFT)) begin
			lim_c = CMP_W'(MAX_SHIFT);
		end
		sh_neg   = SHIFT_W'(-shift_amount_q);
		magraw_c = shift_amount_q[SHIFT_W-1] ? CMP_W'(sh_neg) : CMP_W'(shift_amount_q);
		mag_c    = (magraw_c > lim_c) ? lim_c : magraw_c;
	end

	logic [LEN_W-1:0] cur_len;
	logic [MAG_W-1:0] cur_mag;
	logic             cur_neg;
	logic             col_last;
	logic             emit_c;
	rgb_t             left_px;
	rgb_t             right_px;
	rgb_t             delayed_px;
	rgb_t             current_px;
	logic [PTR_W-1:0] rd_addr_run;
	logic [PTR_W-1:0] wp_next;

	always_comb begin
		if (col_q == '0) begin
			cur_len = LEN_W'(len_c);
			cur_mag = MAG_W'(mag_c);
			cur_neg = shift_amount_q[SHIFT_W-1] && (mag_c != '0);
		end else begin
			cur_len = row_len_q;
			cur_mag = row_mag_q;
			cur_neg = row_neg_q;
		end
		col_last = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(cur_len);
		emit_c   = CMP_W'(col_q) >= CMP_W'(cur_mag);
		left_px  = '{red: pixels.left_red, green: pixels.left_green, blue: pixels.left_blue};
		right_px = '{red: pixels.right_red, green: pixels.right_green,
			blue: pixels.right_blue};
		delayed_px  = cur_neg ? right_px : left_px;
		current_px  = cur_neg ? left_px : right_px;
		rd_addr_run = ring_back(wp_q, cur_mag);
		wp_next     = (wp_q == PTR_W'(MAX_SHIFT - 1)) ? '0 : wp_q + PTR_W'(1);
	end

	// stage 1 and output register
	logic     v_s1;
	s1_kind_t kind_s1;
	logic     last_s1;
	rgb_t     cur_s1;
	rgb_t     dly_s1;
	logic     out_v_q;
	rgb_t     out_px_q;
	logic     out_last_q;
	logic     out_free;
	logic     s1_free;
	logic     in_acc;
	logic     flush_rd;
	rgb_t     rd_data;
	rgb_t     s1_px;

	assign out_free = !out_v_q || blended.ready;
	assign s1_free  = !v_s1 || out_free;
	assign in_acc   = pixels.valid && pixels.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (in_acc && col_last && (cur_mag != '0)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flush_rd && (flush_cnt_q == MAG_W'(1))) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	// state outputs
	always_comb begin
		pixels.ready = 1'b0;
		flush_rd     = 1'b0;
		unique case (state_q)
			ST_RUN:   pixels.ready = s1_free;
			ST_FLUSH: flush_rd     = s1_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			col_q        <= '0;
			row_len_q    <= LEN_W'(1);
			row_mag_q    <= '0;
			row_neg_q    <= 1'b0;
			wp_q         <= '0;
			flush_cnt_q  <= '0;
			flush_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				row_len_q <= cur_len;
				row_mag_q <= cur_mag;
				row_neg_q <= cur_neg;
				wp_q      <= wp_next;
				col_q     <= col_last ? '0 : col_q + COL_W'(1);
				if (col_last) begin
					flush_cnt_q  <= cur_mag;
					flush_addr_q <= ring_back(wp_q, cur_mag - MAG_W'(1));
				end
			end else if (flush_rd) begin
				flush_cnt_q  <= flush_cnt_q - MAG_W'(1);
				flush_addr_q <= (flush_addr_q == PTR_W'(MAX_SHIFT - 1)) ? '0 :
					flush_addr_q + PTR_W'(1);
			end
		end
	end

	ring_ctl_t        ring_ctl;
	logic [PTR_W-1:0] rd_addr;

	assign ring_ctl.wr_en = in_acc;
	assign ring_ctl.rd_en = (in_acc && emit_c && (cur_mag != '0)) || flush_rd;
	assign rd_addr        = (state_q == ST_FLUSH) ? flush_addr_q : rd_addr_run;

	dsb_ring #(
		.DEPTH  (MAX_SHIFT),
		.ADDR_W (PTR_W)
	) u_ring (
		.clk     (clk),
		.ctl     (ring_ctl),
		.wr_addr (wp_q),
		.wr_data (delayed_px),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= emit_c;
		end else if (flush_rd) begin
			v_s1 <= 1'b1;
		end else if (out_free) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= (cur_mag == '0) ? K_BLEND_REG : K_BLEND_MEM;
			last_s1 <= col_last && (cur_mag == '0);
			cur_s1  <= current_px;
			dly_s1  <= delayed_px;
		end else if (flush_rd) begin
			kind_s1 <= K_COPY;
			last_s1 <= (flush_cnt_q == MAG_W'(1));
		end
	end

	always_comb begin
		case (kind_s1)
			K_BLEND_MEM: s1_px = blend(rd_data, cur_s1);
			K_BLEND_REG: s1_px = blend(dly_s1, cur_s1);
			K_COPY:      s1_px = rd_data;
			default:     s1_px = rd_data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (v_s1 && out_free) begin
			out_v_q <= 1'b1;
		end else if (blended.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && out_free) begin
			out_px_q   <= s1_px;
			out_last_q <= last_s1;
		end
	end

	assign blended.valid     = out_v_q;
	assign blended.out_red   = out_px_q.red;
	assign blended.out_green = out_px_q.green;
	assign blended.out_blue  = out_px_q.blue;
	assign blended.row_last  = out_last_q;

	a_flush_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (flush_cnt_q != '0))
		else $error("flush running with zero count");

	a_mag_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(row_mag_q) < CMP_W'(row_len_q))
		else $error("latched shift not below row length");

	a_flush_at_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (col_q == '0))
		else $error("flush while column counter mid-row");

endmodule

`default_nettype wire
